// ===== design/multi_mode_lock_manager_macros.svh =====
// Assertion helpers for the lock manager.
`ifndef MULTI_MODE_LOCK_MANAGER_MACROS_SVH
`define MULTI_MODE_LOCK_MANAGER_MACROS_SVH

`define MMLM_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`define MMLM_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/mmlm_pkg.sv =====
package mmlm_pkg;

    localparam int HOLDER_DEPTH_DEF = 16;
    localparam int WAIT_DEPTH_DEF   = 16;
    localparam int CLIENT_BITS_DEF  = 8;
    localparam int ID_W             = 8;
    localparam int MODE_W           = 3;
    localparam int STATUS_W         = 3;
    localparam int MAX_RESULTS      = 16;

    localparam logic [MODE_W-1:0] MODE_NL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CW = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PW = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EX = 3'd5;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WAITED   = 3'd4;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    // row = held mode, bit = requested mode
    function automatic logic compat(input logic [MODE_W-1:0] held,
                                    input logic [MODE_W-1:0] req);
        logic [5:0] row;
        case (held)
            MODE_NL: row = 6'h3F;
            MODE_CR: row = 6'h1F;
            MODE_CW: row = 6'h07;
            MODE_PR: row = 6'h0B;
            MODE_PW: row = 6'h03;
            default: row = 6'h01;
        endcase
        if (req > MODE_EX) begin
            return row[5];
        end
        return row[req];
    endfunction

    function automatic logic [MODE_W-1:0] clamp_mode(input logic [MODE_W-1:0] m);
        return (m > MODE_EX) ? MODE_EX : m;
    endfunction

endpackage

// ===== design/mmlm_cell.sv =====
module mmlm_cell #(
    parameter int CW = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mmlm_pkg::cell_ctl_t       ctl,
    input  logic                      nxt_valid,
    input  logic [CW-1:0]             nxt_client,
    input  logic [mmlm_pkg::MODE_W-1:0] nxt_mode,
    input  logic [CW-1:0]             ld_client,
    input  logic [mmlm_pkg::MODE_W-1:0] ld_mode,
    output logic                      valid,
    output logic [CW-1:0]             client,
    output logic [mmlm_pkg::MODE_W-1:0] mode
);
    import mmlm_pkg::*;

    logic              valid_reg, valid_next;
    logic [CW-1:0]     client_reg, client_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    always_comb begin
        valid_next  = valid_reg;
        client_next = client_reg;
        mode_next   = mode_reg;
        if (ctl.shift) begin
            valid_next  = nxt_valid;
            client_next = nxt_client;
            mode_next   = nxt_mode;
        end else if (ctl.load) begin
            valid_next  = 1'b1;
            client_next = ld_client;
            mode_next   = ld_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        client_reg <= client_next;
        mode_reg   <= mode_next;
    end

    assign valid  = valid_reg;
    assign client = client_reg;
    assign mode   = mode_reg;

endmodule

// ===== design/mmlm_store.sv =====
module mmlm_store #(
    parameter int DEPTH = 16,
    parameter int CW    = 8,
    parameter int IW    = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [CW-1:0]               push_client,
    input  logic [mmlm_pkg::MODE_W-1:0] push_mode,
    input  logic                        drop,
    input  logic [IW-1:0]               drop_idx,
    output logic [DEPTH-1:0]            valid,
    output logic [CW-1:0]               client [DEPTH],
    output logic [mmlm_pkg::MODE_W-1:0] mode [DEPTH]
);
    import mmlm_pkg::*;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            cell_ctl_t         ctl;
            logic              ld;
            logic              nv;
            logic [CW-1:0]     nc;
            logic [MODE_W-1:0] nm;

            if (g == DEPTH - 1) begin : g_end
                assign nv = 1'b0;
                assign nc = client[g];
                assign nm = mode[g];
            end else begin : g_mid
                assign nv = valid[g+1];
                assign nc = client[g+1];
                assign nm = mode[g+1];
            end

            if (g == 0) begin : g_first
                assign ld = push && !valid[g];
            end else begin : g_rest
                assign ld = push && !valid[g] && valid[g-1];
            end
            assign ctl = {drop && (IW'(g) >= drop_idx), ld};

            mmlm_cell #(.CW(CW)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .nxt_valid  (nv),
                .nxt_client (nc),
                .nxt_mode   (nm),
                .ld_client  (push_client),
                .ld_mode    (push_mode),
                .valid      (valid[g]),
                .client     (client[g]),
                .mode       (mode[g])
            );
        end
    endgenerate

endmodule

// ===== design/multi_mode_lock_manager.sv =====
// Six-mode lock manager for one shared resource.
// Input channel s_*: one request word (kind, client_id, mode, may_queue).
// Result channel m_*: answer words (target_client, status, last); m_last
// marks the final answer caused by one request.
// A lock request answers with exactly one word, registered in the cycle after
// acceptance; the next request is taken once that word can leave.
// An unlock that releases a holding walks the waiting queue one waiter per
// cycle while the receiver keeps up. Each grant leaves one word. An unlock
// that only cancels a waiting entry, or finds nothing, gives none.
// Holders and waiters live in chains of cells that stay packed; a removal
// shifts all the upper cells down by one together.
// Reset (aresetn low, synchronous) empties both chains and the output.
// When m_ready is low the output word holds, the scan stalls at the next
// grant, and s_ready stays low.
module multi_mode_lock_manager #(
    parameter int HOLDER_DEPTH = mmlm_pkg::HOLDER_DEPTH_DEF,
    parameter int WAIT_DEPTH   = mmlm_pkg::WAIT_DEPTH_DEF,
    parameter int CLIENT_BITS  = mmlm_pkg::CLIENT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [mmlm_pkg::ID_W-1:0]     s_client_id,
    input  logic [mmlm_pkg::MODE_W-1:0]   s_mode,
    input  logic                          s_may_queue,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mmlm_pkg::ID_W-1:0]     m_target_client,
    output logic [mmlm_pkg::STATUS_W-1:0] m_status,
    output logic                          m_last
);
    import mmlm_pkg::*;
    `include "multi_mode_lock_manager_macros.svh"

    localparam int CW  = CLIENT_BITS;
    localparam int HIW = (HOLDER_DEPTH > 1) ? $clog2(HOLDER_DEPTH) : 1;
    localparam int WIW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int SW  = $clog2(WAIT_DEPTH + 1) + 1;
    localparam int NW  = $clog2(MAX_RESULTS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg, state_next;
    logic [SW-1:0] scan_i_reg, scan_i_next;
    logic [NW-1:0] n_reg, n_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_client_reg, pend_client_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_client_reg, out_client_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic [HOLDER_DEPTH-1:0] hv;
    logic [CW-1:0]           hc [HOLDER_DEPTH];
    logic [MODE_W-1:0]       hm [HOLDER_DEPTH];
    logic [WAIT_DEPTH-1:0]   wv;
    logic [CW-1:0]           wc [WAIT_DEPTH];
    logic [MODE_W-1:0]       wm [WAIT_DEPTH];

    logic              hpush, hdrop, wpush, wdrop;
    logic [CW-1:0]     hpush_c;
    logic [MODE_W-1:0] hpush_m;
    logic [HIW-1:0]    hdrop_idx;
    logic [WIW-1:0]    wdrop_idx;

    logic [CW-1:0]     cid;
    logic [MODE_W-1:0] cmode;
    logic [MODE_W-1:0] fmode;
    logic              fits;
    logic              hfound, wfound;
    logic [HIW-1:0]    hidx;
    logic [WIW-1:0]    widx;
    logic [WIW-1:0]    sidx;
    logic              out_free;
    logic              scan_done;

    function automatic logic [ID_W-1:0] to_id(input logic [CW-1:0] c);
        logic [CW+ID_W-1:0] ext;
        ext = {{ID_W{1'b0}}, c};
        return ext[ID_W-1:0];
    endfunction

    always_comb begin
        logic [CW+ID_W-1:0] ext;
        ext   = {{CW{1'b0}}, s_client_id};
        cid   = ext[CW-1:0];
        cmode = clamp_mode(s_mode);
    end

    assign sidx     = scan_i_reg[WIW-1:0];
    assign fmode    = (state_reg == ST_SCAN) ? wm[sidx] : cmode;
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    always_comb begin
        fits = 1'b1;
        for (int i = 0; i < HOLDER_DEPTH; i++) begin
            if (hv[i] && !compat(hm[i], fmode)) begin
                fits = 1'b0;
            end
        end
    end

    always_comb begin
        hfound = 1'b0;
        hidx   = '0;
        for (int i = 0; i < HOLDER_DEPTH; i++) begin
            if (hv[i] && hc[i] == cid) begin
                hfound = 1'b1;
                hidx   = HIW'(i);
            end
        end
        wfound = 1'b0;
        widx   = '0;
        for (int i = WAIT_DEPTH - 1; i >= 0; i--) begin
            if (wv[i] && wc[i] == cid) begin
                wfound = 1'b1;
                widx   = WIW'(i);
            end
        end
    end

    assign scan_done = (scan_i_reg >= SW'(WAIT_DEPTH)) || !wv[sidx]
                       || (n_reg == NW'(MAX_RESULTS));

    always_comb begin
        state_next       = state_reg;
        scan_i_next      = scan_i_reg;
        n_next           = n_reg;
        pend_next        = pend_reg;
        pend_client_next = pend_client_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_client_next  = out_client_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        hpush     = 1'b0;
        hpush_c   = cid;
        hpush_m   = cmode;
        hdrop     = 1'b0;
        hdrop_idx = hidx;
        wpush     = 1'b0;
        wdrop     = 1'b0;
        wdrop_idx = widx;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (!s_kind) begin
                        out_valid_next  = 1'b1;
                        out_client_next = to_id(cid);
                        out_last_next   = 1'b1;
                        if (fits) begin
                            if (!hv[HOLDER_DEPTH-1]) begin
                                hpush           = 1'b1;
                                out_status_next = ST_GRANTED;
                            end else begin
                                out_status_next = ST_NO_ROOM;
                            end
                        end else if (s_may_queue) begin
                            if (!wv[WAIT_DEPTH-1]) begin
                                wpush           = 1'b1;
                                out_status_next = ST_ENQUEUED;
                            end else begin
                                out_status_next = ST_NO_ROOM;
                            end
                        end else begin
                            out_status_next = ST_BUSY;
                        end
                    end else if (hfound) begin
                        hdrop       = 1'b1;
                        state_next  = ST_SCAN;
                        scan_i_next = '0;
                        n_next      = '0;
                    end else if (wfound) begin
                        wdrop = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    if (!pend_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_client_next = to_id(pend_client_reg);
                        out_status_next = ST_WAITED;
                        out_last_next   = 1'b1;
                        pend_next       = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else if (fits && !hv[HOLDER_DEPTH-1]) begin
                    if (!pend_reg || out_free) begin
                        if (pend_reg) begin
                            out_valid_next  = 1'b1;
                            out_client_next = to_id(pend_client_reg);
                            out_status_next = ST_WAITED;
                            out_last_next   = 1'b0;
                        end
                        pend_next        = 1'b1;
                        pend_client_next = wc[sidx];
                        hpush            = 1'b1;
                        hpush_c          = wc[sidx];
                        hpush_m          = wm[sidx];
                        wdrop            = 1'b1;
                        wdrop_idx        = sidx;
                        n_next           = n_reg + 1'b1;
                    end
                end else begin
                    scan_i_next = scan_i_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_i_reg    <= '0;
            n_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            scan_i_reg    <= scan_i_next;
            n_reg         <= n_next;
        end
        pend_client_reg <= pend_client_next;
        out_client_reg  <= out_client_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    mmlm_store #(.DEPTH(HOLDER_DEPTH), .CW(CW), .IW(HIW)) u_holders (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (hpush),
        .push_client (hpush_c),
        .push_mode   (hpush_m),
        .drop        (hdrop),
        .drop_idx    (hdrop_idx),
        .valid       (hv),
        .client      (hc),
        .mode        (hm)
    );

    mmlm_store #(.DEPTH(WAIT_DEPTH), .CW(CW), .IW(WIW)) u_waiters (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (wpush),
        .push_client (cid),
        .push_mode   (cmode),
        .drop        (wdrop),
        .drop_idx    (wdrop_idx),
        .valid       (wv),
        .client      (wc),
        .mode        (wm)
    );

    assign m_valid         = out_valid_reg;
    assign m_target_client = out_client_reg;
    assign m_status        = out_status_reg;
    assign m_last          = out_last_reg;

    `MMLM_ALWAYS(a_holders_packed, ((hv + 1'b1) & hv) == '0, "holder chain has a gap")
    `MMLM_ALWAYS(a_waiters_packed, ((wv + 1'b1) & wv) == '0, "wait chain has a gap")
    `MMLM_ALWAYS(a_pend_in_scan, (state_reg == ST_SCAN) || !pend_reg,
                 "pending grant outside a scan")
    `MMLM_IMPLIES(a_unlock_keeps_waiters, s_valid && s_ready && s_kind,
                  $countones(wv) + 1 >= $countones($past(wv)),
                  "unlock dropped more than one waiter")

endmodule
